// ===== hdl/matrix_polynomial_eval_defines.svh =====
// Assertion macros used by the checked top-level module.
`ifndef MATRIX_POLYNOMIAL_EVAL_DEFINES_SVH
`define MATRIX_POLYNOMIAL_EVAL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mpe_pkg.sv =====
package mpe_pkg;

    // Default sizes
    localparam int DEF_MAX_DIM    = 8;
    localparam int DEF_MAX_DEGREE = 15;
    localparam int DEF_DATA_WIDTH = 32;

    // Register file
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_DIMENSION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEGREE    = 1'b1;
    localparam logic [CFG_DATA_W-1:0]  DIM_RESET     = 4'd2;
    localparam logic [CFG_DATA_W-1:0]  DEG_RESET     = 4'd1;

    // Input word kinds
    localparam logic OP_ELEMENT = 1'b0;
    localparam logic OP_COEFF   = 1'b1;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int RESULT_W   = 32;
    localparam int ROWCOL_W   = 3;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - 2 * ROWCOL_W - RESULT_W;

    // Controller to datapath commands
    typedef struct packed {
        logic mat_we;
        logic coef_we;
        logic c_load;
        logic init_we;
        logic init_diag;
        logic mac_issue;
        logic mac_first;
        logic mac_last;
        logic mac_diag;
        logic bank_sel;
        logic out_load;
    } mpe_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;
        logic out_taken;
    } mpe_stat_t;

endpackage

// ===== hdl/mpe_ram.sv =====
module mpe_ram import mpe_pkg::*; #(
    parameter int WIDTH = DEF_DATA_WIDTH,
    parameter int DEPTH = DEF_MAX_DIM * DEF_MAX_DIM,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/mpe_ctrl.sv =====
module mpe_ctrl import mpe_pkg::*; #(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    localparam int CELLS     = MAX_DIM * MAX_DIM,
    localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int GW        = $clog2(MAX_DEGREE + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tuser,
    output logic                   s_tready,
    output mpe_cmd_t               cmd,
    input  mpe_stat_t              stat,
    output logic [AW-1:0]          mat_waddr,
    output logic [AW-1:0]          mat_raddr,
    output logic [AW-1:0]          acc_waddr,
    output logic [AW-1:0]          acc_raddr,
    output logic [GW-1:0]          coef_waddr,
    output logic [GW-1:0]          coef_raddr,
    output logic [ROWCOL_W-1:0]    out_row,
    output logic [ROWCOL_W-1:0]    out_col,
    output logic                   out_last
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NW    = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int CCW   = $clog2(MAX_DEGREE + 2);

    typedef enum logic [3:0] {
        ST_IDLE, ST_REALIGN, ST_C_RD, ST_C_LD, ST_INIT, ST_S_RD, ST_S_LD,
        ST_MAC, ST_DRAIN, ST_O_RD, ST_O_LD, ST_O_WAIT
    } state_t;

    state_t               state_reg;
    logic [CFG_DATA_W-1:0] dim_reg, deg_reg;
    logic [CNT_W-1:0]     elem_cnt_reg, row_reg, rem_reg;
    logic [IDX_W-1:0]     col_reg;
    logic [CCW-1:0]       coef_cnt_reg;
    logic [IDX_W-1:0]     r_reg, k_reg, j_reg;
    logic [GW-1:0]        i_reg;
    logic                 sel_reg;

    logic [NW-1:0]    n_act;
    logic [GW-1:0]    g_act;
    logic [CNT_W-1:0] n_sq;
    logic [IDX_W-1:0] n_top;
    logic             accept, mat_store, coef_store, coef_done;
    logic             r_end, k_end, j_end;

    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // Active sizes, clamped to the supported range
    always_comb begin
        if (dim_reg == '0) begin
            n_act = NW'(1);
        end else if (int'(dim_reg) > MAX_DIM) begin
            n_act = NW'(MAX_DIM);
        end else begin
            n_act = NW'(dim_reg);
        end
        if (int'(deg_reg) > MAX_DEGREE) begin
            g_act = GW'(MAX_DEGREE);
        end else begin
            g_act = GW'(deg_reg);
        end
        n_sq  = CNT_W'(int'(n_act) * int'(n_act));
        n_top = IDX_W'(n_act - NW'(1));
    end

    assign accept     = s_tvalid && s_tready;
    assign mat_store  = accept && (s_tuser == OP_ELEMENT) && (elem_cnt_reg < n_sq);
    assign coef_store = accept && (s_tuser == OP_COEFF) && (coef_cnt_reg <= CCW'(g_act));
    assign coef_done  = accept && (s_tuser == OP_COEFF) &&
                        ((coef_cnt_reg + CCW'(1)) > CCW'(g_act));
    assign r_end      = (r_reg == n_top);
    assign k_end      = (k_reg == n_top);
    assign j_end      = (j_reg == n_top);

    // State, counters and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dim_reg      <= DIM_RESET;
            deg_reg      <= DEG_RESET;
            elem_cnt_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            rem_reg      <= '0;
            coef_cnt_reg <= '0;
            r_reg        <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            i_reg        <= '0;
            sel_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DIMENSION: dim_reg <= cfg_wdata;
                    REG_DEGREE:    deg_reg <= cfg_wdata;
                    default:       ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (mat_store) begin
                        elem_cnt_reg <= elem_cnt_reg + CNT_W'(1);
                        if (col_reg == n_top) begin
                            col_reg <= '0;
                            row_reg <= row_reg + CNT_W'(1);
                        end else begin
                            col_reg <= col_reg + IDX_W'(1);
                        end
                    end
                    if (accept && s_tuser == OP_COEFF) begin
                        coef_cnt_reg <= coef_cnt_reg + CCW'(1);
                    end
                    if (cfg_we && cfg_index == REG_DIMENSION) begin
                        // redo row/column split of the fill count for the new size
                        rem_reg   <= elem_cnt_reg;
                        row_reg   <= '0;
                        state_reg <= ST_REALIGN;
                    end
                    if (coef_done) begin
                        elem_cnt_reg <= '0;
                        row_reg      <= '0;
                        col_reg      <= '0;
                        coef_cnt_reg <= '0;
                        i_reg        <= g_act;
                        state_reg    <= ST_C_RD;
                    end
                end
                ST_REALIGN: begin
                    if (cfg_we && cfg_index == REG_DIMENSION) begin
                        rem_reg <= elem_cnt_reg;
                        row_reg <= '0;
                    end else if (rem_reg >= CNT_W'(n_act)) begin
                        rem_reg <= rem_reg - CNT_W'(n_act);
                        row_reg <= row_reg + CNT_W'(1);
                    end else begin
                        col_reg   <= IDX_W'(rem_reg);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_C_RD: state_reg <= ST_C_LD;
                ST_C_LD: begin
                    r_reg     <= '0;
                    k_reg     <= '0;
                    state_reg <= ST_INIT;
                end
                ST_INIT: begin
                    if (k_end) begin
                        k_reg <= '0;
                        r_reg <= r_reg + IDX_W'(1);
                        if (r_end) begin
                            r_reg     <= '0;
                            sel_reg   <= 1'b0;
                            state_reg <= (i_reg == '0) ? ST_O_RD : ST_S_RD;
                        end
                    end else begin
                        k_reg <= k_reg + IDX_W'(1);
                    end
                end
                ST_S_RD: state_reg <= ST_S_LD;
                ST_S_LD: begin
                    r_reg     <= '0;
                    k_reg     <= '0;
                    j_reg     <= '0;
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    if (j_end) begin
                        j_reg <= '0;
                        if (k_end) begin
                            k_reg <= '0;
                            if (r_end) begin
                                r_reg     <= '0;
                                state_reg <= ST_DRAIN;
                            end else begin
                                r_reg <= r_reg + IDX_W'(1);
                            end
                        end else begin
                            k_reg <= k_reg + IDX_W'(1);
                        end
                    end else begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!stat.pipe_busy) begin
                        sel_reg   <= ~sel_reg;
                        i_reg     <= i_reg - GW'(1);
                        state_reg <= (i_reg == GW'(1)) ? ST_O_RD : ST_S_RD;
                    end
                end
                ST_O_RD: state_reg <= ST_O_LD;
                ST_O_LD: state_reg <= ST_O_WAIT;
                ST_O_WAIT: begin
                    if (stat.out_taken) begin
                        if (out_last) begin
                            r_reg     <= '0;
                            k_reg     <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_O_RD;
                            if (k_end) begin
                                k_reg <= '0;
                                r_reg <= r_reg + IDX_W'(1);
                            end else begin
                                k_reg <= k_reg + IDX_W'(1);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Addresses
    assign mat_waddr  = cell_addr(row_reg[IDX_W-1:0], col_reg);
    assign mat_raddr  = cell_addr(j_reg, k_reg);
    assign acc_waddr  = cell_addr(r_reg, k_reg);
    assign acc_raddr  = (state_reg == ST_MAC) ? cell_addr(r_reg, j_reg)
                                              : cell_addr(r_reg, k_reg);
    assign coef_waddr = GW'(coef_cnt_reg);
    assign coef_raddr = (state_reg == ST_C_RD) ? i_reg : i_reg - GW'(1);
    assign out_row    = ROWCOL_W'(r_reg);
    assign out_col    = ROWCOL_W'(k_reg);
    assign out_last   = r_end && k_end;
    // input closed during reset
    assign s_tready   = aresetn && (state_reg == ST_IDLE);

    // Commands
    always_comb begin
        cmd.mat_we    = mat_store;
        cmd.coef_we   = coef_store;
        cmd.c_load    = (state_reg == ST_C_LD) || (state_reg == ST_S_LD);
        cmd.init_we   = (state_reg == ST_INIT);
        cmd.init_diag = (r_reg == k_reg);
        cmd.mac_issue = (state_reg == ST_MAC);
        cmd.mac_first = (j_reg == '0);
        cmd.mac_last  = j_end;
        cmd.mac_diag  = (r_reg == k_reg);
        cmd.bank_sel  = sel_reg;
        cmd.out_load  = (state_reg == ST_O_LD);
    end

endmodule

// ===== hdl/mpe_datapath.sv =====
module mpe_datapath import mpe_pkg::*; #(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int CELLS     = MAX_DIM * MAX_DIM,
    localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int GW        = $clog2(MAX_DEGREE + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mpe_cmd_t             cmd,
    output mpe_stat_t            stat,
    input  logic [VALUE_W-1:0]   s_tdata,
    input  logic [AW-1:0]        mat_waddr,
    input  logic [AW-1:0]        mat_raddr,
    input  logic [AW-1:0]        acc_waddr,
    input  logic [AW-1:0]        acc_raddr,
    input  logic [GW-1:0]        coef_waddr,
    input  logic [GW-1:0]        coef_raddr,
    input  logic [ROWCOL_W-1:0]  out_row,
    input  logic [ROWCOL_W-1:0]  out_col,
    input  logic                 out_last,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic [DATA_WIDTH-1:0] val_w, mat_q, coef_q, bank0_q, bank1_q, acc_q;
    logic [DATA_WIDTH-1:0] c_reg, p_reg, sum_reg, sum_next, mac_wdata, init_wdata;
    logic [DATA_WIDTH-1:0] bank_wdata;
    logic [AW-1:0]         waddr_q1, waddr_q2, bank_waddr;
    logic                  v_q1, v_q2, first_q1, first_q2, last_q1, last_q2;
    logic                  diag_q1, diag_q2, mac_we, bank0_we, bank1_we;
    logic                  out_valid_reg, out_last_reg;
    logic [ROWCOL_W-1:0]   out_row_reg, out_col_reg;
    logic [RESULT_W-1:0]   out_res_reg;

    // Incoming word, sign-extended or cut to the working width
    assign val_w = DATA_WIDTH'($signed(s_tdata));

    mpe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CELLS)) u_mat (
        .aclk(aclk), .we(cmd.mat_we), .waddr(mat_waddr), .wdata(val_w),
        .raddr(mat_raddr), .rdata(mat_q)
    );

    mpe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_DEGREE + 1)) u_coef (
        .aclk(aclk), .we(cmd.coef_we), .waddr(coef_waddr), .wdata(val_w),
        .raddr(coef_raddr), .rdata(coef_q)
    );

    // Ping-pong accumulator banks: read from bank_sel, MAC results go to the other one; init writes bank 0
    assign init_wdata = cmd.init_diag ? c_reg : '0;
    assign mac_we     = v_q2 && last_q2;
    assign bank_wdata = cmd.init_we ? init_wdata : mac_wdata;
    assign bank_waddr = cmd.init_we ? acc_waddr : waddr_q2;
    assign bank0_we   = cmd.init_we || (mac_we && cmd.bank_sel);
    assign bank1_we   = mac_we && !cmd.bank_sel;

    mpe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CELLS)) u_bank0 (
        .aclk(aclk), .we(bank0_we), .waddr(bank_waddr), .wdata(bank_wdata),
        .raddr(acc_raddr), .rdata(bank0_q)
    );

    mpe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CELLS)) u_bank1 (
        .aclk(aclk), .we(bank1_we), .waddr(bank_waddr), .wdata(bank_wdata),
        .raddr(acc_raddr), .rdata(bank1_q)
    );

    assign acc_q = cmd.bank_sel ? bank1_q : bank0_q;

    // Running sum and diagonal term
    assign sum_next  = (first_q2 ? '0 : sum_reg) + p_reg;
    assign mac_wdata = sum_next + (diag_q2 ? c_reg : '0);

    // MAC pipeline: issue, read, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_q1 <= 1'b0;
            v_q2 <= 1'b0;
        end else begin
            v_q1 <= cmd.mac_issue;
            v_q2 <= v_q1;
        end
        first_q1 <= cmd.mac_first;
        last_q1  <= cmd.mac_last;
        diag_q1  <= cmd.mac_diag;
        waddr_q1 <= acc_waddr;
        first_q2 <= first_q1;
        last_q2  <= last_q1;
        diag_q2  <= diag_q1;
        waddr_q2 <= waddr_q1;
        p_reg    <= DATA_WIDTH'(acc_q * mat_q);
        if (v_q2) begin
            sum_reg <= sum_next;
        end
        if (cmd.c_load) begin
            c_reg <= coef_q;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_res_reg  <= RESULT_W'(acc_q);
            out_row_reg  <= out_row;
            out_col_reg  <= out_col;
            out_last_reg <= out_last;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = {{M_PAD_W{1'b0}}, out_res_reg, out_col_reg, out_row_reg};
    assign m_tlast        = out_last_reg;
    assign stat.pipe_busy = v_q1 || v_q2;
    assign stat.out_taken = out_valid_reg && m_tready;

endmodule

// ===== hdl/matrix_polynomial_eval.sv =====
// Matrix polynomial evaluator: p(A) = c0*I + c1*A + ... + cd*A^d, wrapping arithmetic.
// Set dimension (index 0) and degree (index 1) on the cfg port while idle.
// Input words: s_tuser 0 loads the next element of A in row-major order, 1 loads
// the next coefficient from c0 up.
// The coefficient cd starts the evaluation by Horner's rule on one shared MAC,
// one multiply-add a cycle.
// The result leaves row-major on m_*, one word per element, m_tlast on the last;
// each output word is read, loaded and then held until m_tready takes it.
// s_tready is low during reset, from the final coefficient until the last result
// word is taken, and after a dimension write while the fill position is recomputed.
// A stalled m_tready holds the current word and the whole block.
// Reset gives dimension 2, degree 1 and empty load counts; the matrix and
// coefficient memories are not cleared and must be loaded before use.
`include "matrix_polynomial_eval_defines.svh"

module matrix_polynomial_eval import mpe_pkg::*; #(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,  // value[31:0]
    input  logic                   s_tuser,  // operation[0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,  // row[2:0], column[5:3], result[37:6], zero
    output logic                   m_tlast
);

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int GW    = $clog2(MAX_DEGREE + 1);

    mpe_cmd_t            cmd;
    mpe_stat_t           stat;
    logic [AW-1:0]       mat_waddr, mat_raddr, acc_waddr, acc_raddr;
    logic [GW-1:0]       coef_waddr, coef_raddr;
    logic [ROWCOL_W-1:0] out_row, out_col;
    logic                out_last;

    mpe_ctrl #(.MAX_DIM(MAX_DIM), .MAX_DEGREE(MAX_DEGREE)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tuser(s_tuser), .s_tready(s_tready),
        .cmd(cmd), .stat(stat),
        .mat_waddr(mat_waddr), .mat_raddr(mat_raddr),
        .acc_waddr(acc_waddr), .acc_raddr(acc_raddr),
        .coef_waddr(coef_waddr), .coef_raddr(coef_raddr),
        .out_row(out_row), .out_col(out_col), .out_last(out_last)
    );

    mpe_datapath #(
        .MAX_DIM(MAX_DIM), .MAX_DEGREE(MAX_DEGREE), .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .s_tdata(s_tdata),
        .mat_waddr(mat_waddr), .mat_raddr(mat_raddr),
        .acc_waddr(acc_waddr), .acc_raddr(acc_raddr),
        .coef_waddr(coef_waddr), .coef_raddr(coef_raddr),
        .out_row(out_row), .out_col(out_col), .out_last(out_last),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // Input side stays closed while a result word is pending
    `MPE_ASSERT_IMP(a_no_load_during_out, m_tvalid, !s_tready, "input open during output")
    // After the last word the block is ready for a new load
    `MPE_ASSERT_NXT(a_idle_after_last, m_tvalid && m_tready && m_tlast, s_tready,
                    "not idle after last word")
    // Each following word needs a fresh read of the accumulator
    `MPE_ASSERT_NXT(a_gap_between_words, m_tvalid && m_tready && !m_tlast, !m_tvalid,
                    "output word repeated")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mpe_pkg::*;

    localparam int CELLS     = 64;
    localparam int STALL_MAX = 40000;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] elem;
        logic        last;
    } poly_elem_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_DIMENSION;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata = '0;   // value[31:0]
    logic                   s_tuser = OP_ELEMENT;   // operation[0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;   // row[2:0], column[5:3], result[37:6], zero
    logic                   m_tlast;

    matrix_polynomial_eval u_dut (.*);

    always #10 aclk = ~aclk;

    // Shadow of the block's registers and stores
    logic [3:0]  dim_reg = DIM_RESET;
    logic [3:0]  deg_reg = DEG_RESET;
    logic [31:0] mat_mem [CELLS];
    logic        mat_written [CELLS];
    logic [31:0] coef_mem [16];
    logic [31:0] acc_m [CELLS];
    logic [31:0] tmp_m [CELLS];
    int          elems_loaded = 0;
    int          coefs_loaded = 0;

    poly_elem_t  poly_q [$];
    int          send_pct = 0;
    int          recv_pct = 0;
    int          hold_cycles = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          words_sent = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    function automatic int cur_dim();
        if (dim_reg == 0) return 1;
        if (dim_reg > 8) return 8;
        return dim_reg;
    endfunction

    function automatic bit matrix_ready(int n);
        for (int r = 0; r < n; r++)
            for (int k = 0; k < n; k++)
                if (!mat_written[r * 8 + k]) return 1'b0;
        return 1'b1;
    endfunction

    // Horner evaluation of the accepted coefficients over the shadow matrix
    task automatic eval_poly(int n, int g);
        logic [31:0] s;
        for (int c = 0; c < CELLS; c++) acc_m[c] = '0;
        for (int r = 0; r < n; r++) acc_m[r * 8 + r] = coef_mem[g];
        for (int i = g; i > 0; i--) begin
            for (int r = 0; r < n; r++)
                for (int k = 0; k < n; k++) begin
                    s = (r == k) ? coef_mem[i - 1] : '0;
                    for (int j = 0; j < n; j++) s += acc_m[r * 8 + j] * mat_mem[j * 8 + k];
                    tmp_m[r * 8 + k] = s;
                end
            acc_m = tmp_m;
        end
        for (int r = 0; r < n; r++)
            for (int k = 0; k < n; k++)
                poly_q.insert(poly_q.size(),
                              '{r[2:0], k[2:0], acc_m[r * 8 + k], (r == n - 1 && k == n - 1)});
    endtask

    task automatic predict_word(logic op, logic [31:0] v);
        int n;
        int g;
        n = cur_dim();
        g = deg_reg;
        if (op == OP_ELEMENT) begin
            if (elems_loaded < n * n) begin
                mat_mem[(elems_loaded / n) * 8 + elems_loaded % n] = v;
                mat_written[(elems_loaded / n) * 8 + elems_loaded % n] = 1'b1;
                elems_loaded++;
            end
        end else begin
            if (coefs_loaded <= g) coef_mem[coefs_loaded] = v;
            coefs_loaded++;
            if (coefs_loaded > g) begin
                eval_poly(n, g);
                elems_loaded = 0;
                coefs_loaded = 0;
            end
        end
    endtask

    // Send one word, with a random gap ahead of it
    task automatic send_word(logic op, logic [31:0] v);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(op, v);
        words_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Pause until every expected word is back, then let the block settle
    task automatic wait_drained();
        stop_sending();
        while (poly_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [3:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        if (idx == REG_DIMENSION) dim_reg = v;
        else deg_reg = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4, 5, 6: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom();
        endcase
    endfunction

    // One load-and-evaluate sequence under the current registers
    task automatic run_sequence();
        int n;
        int g;
        int k;
        int early;
        n = cur_dim();
        g = deg_reg;
        if (!matrix_ready(n) || $urandom_range(0, 3) != 0) begin
            for (int i = 0; i < n * n; i++) send_word(OP_ELEMENT, rand_value());
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_word(OP_ELEMENT, rand_value());
            for (int i = 0; i <= g; i++) send_word(OP_COEFF, rand_value());
        end else begin
            // partial reload, with some coefficients ahead of the elements
            k = $urandom_range(0, n * n - 1);
            early = $urandom_range(0, g);
            for (int i = 0; i < early; i++) send_word(OP_COEFF, rand_value());
            for (int i = 0; i < k; i++) send_word(OP_ELEMENT, rand_value());
            for (int i = early; i <= g; i++) send_word(OP_COEFF, rand_value());
        end
    endtask

    // Receiver: random stalls plus an optional long hold-off
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_cycles <= 400;
            m_tready    <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        poly_elem_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (poly_q.size() == 0) begin
                $display("%0t: unexpected word %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = poly_q.pop_front();
                if (m_tdata[2:0] !== want.row || m_tdata[5:3] !== want.col ||
                    m_tdata[37:6] !== want.elem || m_tlast !== want.last)
                begin
                    $display("%0t: mismatch exp r%0d c%0d %h last %b, got r%0d c%0d %h last %b",
                             $time, want.row, want.col, want.elem, want.last,
                             m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // Reset values: dimension 2, degree 1
    task automatic test_reset_defaults();
        run_sequence();
        wait_drained();
    endtask

    // Smallest and largest sizes with extreme values
    task automatic test_extremes();
        write_reg(REG_DIMENSION, 4'd1);
        write_reg(REG_DEGREE, 4'd0);
        send_word(OP_ELEMENT, 32'h8000_0000);
        send_word(OP_COEFF, 32'h7fff_ffff);
        wait_drained();
        write_reg(REG_DIMENSION, 4'd8);
        write_reg(REG_DEGREE, 4'd15);
        for (int i = 0; i < 64; i++) send_word(OP_ELEMENT, (i % 2) ? 32'hffff_ffff : 32'h8000_0000);
        for (int i = 0; i < 16; i++) send_word(OP_COEFF, rand_value());
        wait_drained();
    endtask

    // Out-of-range dimensions, matrix reuse, surplus words, change mid-load
    task automatic test_special_cases();
        write_reg(REG_DEGREE, 4'd2);
        write_reg(REG_DIMENSION, 4'd0);
        for (int i = 0; i < 3; i++) send_word(OP_COEFF, rand_value());
        wait_drained();
        write_reg(REG_DIMENSION, 4'd15);
        for (int i = 0; i < 3; i++) send_word(OP_COEFF, 32'($signed(i) - 1));
        wait_drained();
        write_reg(REG_DIMENSION, 4'd2);
        write_reg(REG_DEGREE, 4'd1);
        for (int i = 0; i < 6; i++) send_word(OP_ELEMENT, rand_value());
        send_word(OP_COEFF, 32'd3);
        send_word(OP_COEFF, 32'hffff_fffe);
        wait_drained();
        send_word(OP_ELEMENT, 32'd5);
        send_word(OP_ELEMENT, 32'd7);
        wait_drained();
        write_reg(REG_DIMENSION, 4'd3);
        for (int i = 0; i < 7; i++) send_word(OP_ELEMENT, rand_value());
        send_word(OP_COEFF, 32'd1);
        send_word(OP_COEFF, 32'd2);
        wait_drained();
    endtask

    // Random registers and sequences under one idling pattern
    task automatic test_random(int sp, int rp, int words);
        int stop_at;
        stop_at = words_sent + words;
        send_pct = sp;
        recv_pct = rp;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_DIMENSION, 4'($urandom_range(0, 15)));
            else
                write_reg(REG_DIMENSION, 4'($urandom_range(1, 4)));
            if (cur_dim() > 4 && $urandom_range(0, 1) == 0)
                write_reg(REG_DEGREE, 4'($urandom_range(0, 3)));
            else
                write_reg(REG_DEGREE, 4'($urandom_range(0, $urandom_range(0, 1) ? 15 : 3)));
            run_sequence();
            if ($urandom_range(0, 2) != 0) run_sequence();
            wait_drained();
        end
    endtask

    // Receiver holds off while the sender keeps offering words
    task automatic test_pressure();
        send_pct = 0;
        recv_pct = 0;
        write_reg(REG_DIMENSION, 4'd2);
        write_reg(REG_DEGREE, 4'd1);
        @(negedge aclk);
        hold_req++;
        repeat (3) run_sequence();
        wait_drained();
    endtask

    initial begin
        for (int c = 0; c < CELLS; c++) mat_written[c] = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);
        test_reset_defaults();
        test_extremes();
        test_special_cases();
        test_random(0, 0, 15);
        test_random(53, 0, 15);
        test_random(0, 53, 15);
        test_random(26, 26, 15);
        test_pressure();
        wait_drained();
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mpe_pkg.sv
hdl/mpe_ram.sv
hdl/mpe_ctrl.sv
hdl/mpe_datapath.sv
hdl/matrix_polynomial_eval.sv
verif/tb.sv
